// File: design/slmph_pkg.sv
package slmph_pkg;

	// field widths
	localparam int LEVEL_IN_W = 17;
	localparam int COEF_W     = 16;
	localparam int SEG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// parameter defaults
	localparam int DEFAULT_LEVEL_FRAC_BITS = 15;
	localparam int DEFAULT_MAX_SEGMENTS    = 32;

	// register reset values
	localparam logic [COEF_W-1:0] ATTACK_RESET  = 16'd22938;
	localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd5243;
	localparam logic [COEF_W-1:0] DECAY_RESET   = 16'd63570;
	localparam logic [SEG_W-1:0]  SEGMENT_RESET = 6'd18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 2'd3;

	// item codes
	localparam logic ACT_LEVEL = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_target;
		logic smooth;
		logic decay;
		logic lit;
		logic peak;
		logic load_out;
	} cmd_t;

endpackage

// File: design/slmph_ctrl.sv
module slmph_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	output logic               out_valid,
	input  logic               out_stall,
	output slmph_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SMOOTH = 5'b00010,
		ST_DECAY  = 5'b00100,
		ST_LIT    = 5'b01000,
		ST_PEAK   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_take;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (action == slmph_pkg::ACT_TICK) begin
						state_d = ST_SMOOTH;
					end else begin
						cmd.load_target = 1'b1;
					end
				end
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_DECAY;
			end
			ST_DECAY: begin
				cmd.decay = 1'b1;
				state_d   = ST_LIT;
			end
			ST_LIT: begin
				cmd.lit = 1'b1;
				state_d = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.peak = 1'b1;
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/slmph_lane.sv
module slmph_lane #(
	parameter int LEVEL_FRAC_BITS = slmph_pkg::DEFAULT_LEVEL_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  slmph_pkg::cmd_t                       cmd,
	input  logic signed [slmph_pkg::LEVEL_IN_W-1:0] level,
	input  logic [slmph_pkg::COEF_W-1:0]          attack_coef,
	input  logic [slmph_pkg::COEF_W-1:0]          release_coef,
	input  logic [slmph_pkg::COEF_W-1:0]          peak_decay,
	input  logic [slmph_pkg::SEG_W-1:0]           seg,
	output logic [slmph_pkg::SEG_W-1:0]           lit,
	output logic [slmph_pkg::SEG_W-1:0]           peak
);

	// stored levels never exceed one or 16 bits, whichever is smaller
	localparam int LW  = (LEVEL_FRAC_BITS + 1 < 16) ? LEVEL_FRAC_BITS + 1 : 16;
	localparam int AW  = LW + 1;
	localparam int BW  = slmph_pkg::COEF_W + 1;
	localparam int PW  = AW + BW;
	localparam int NW  = PW - LEVEL_FRAC_BITS;
	localparam int CLW = (LEVEL_FRAC_BITS + 1 > 17) ? LEVEL_FRAC_BITS + 1 : 17;
	localparam logic [CLW-1:0] ONE_C = CLW'(1) << LEVEL_FRAC_BITS;
	localparam logic [PW-1:0]  HALF  = PW'(1) << (LEVEL_FRAC_BITS - 1);

	logic [LW-1:0]          target_q;
	logic [LW-1:0]          shown_q;
	logic [LW-1:0]          hold_q;
	logic [slmph_pkg::SEG_W-1:0] lit_q;

	logic [CLW-1:0]         clamp_v;
	logic [LW-1:0]          target_nx;
	logic signed [AW-1:0]   mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [PW-1:0]   prod;
	logic [AW-1:0]          step_v;
	logic [AW-1:0]          sm_sum;
	logic [LW-1:0]          shown_nx;
	logic [LW-1:0]          decayed;
	logic [LW-1:0]          hold_nx;
	logic [PW-1:0]          rnd;
	logic [NW-1:0]          n_full;
	logic [slmph_pkg::SEG_W-1:0] n_seg;
	logic [slmph_pkg::COEF_W-1:0] coef_sel;

	// clamp incoming level to 0..one
	always_comb begin
		if (level[slmph_pkg::LEVEL_IN_W-1]) begin
			clamp_v = '0;
		end else if (CLW'(level[slmph_pkg::LEVEL_IN_W-2:0]) > ONE_C) begin
			clamp_v = ONE_C;
		end else begin
			clamp_v = CLW'(level[slmph_pkg::LEVEL_IN_W-2:0]);
		end
		target_nx = clamp_v[LW-1:0];
	end

	// shared multiplier operand select
	assign coef_sel = (target_q > shown_q) ? attack_coef : release_coef;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.smooth) begin
			mul_a = $signed({1'b0, target_q}) - $signed({1'b0, shown_q});
			mul_b = $signed({1'b0, coef_sel});
		end else if (cmd.decay) begin
			mul_a = $signed({1'b0, hold_q});
			mul_b = $signed({1'b0, peak_decay});
		end else if (cmd.lit) begin
			mul_a = $signed({1'b0, shown_q});
			mul_b = $signed({{(BW - slmph_pkg::SEG_W){1'b0}}, seg});
		end else if (cmd.peak) begin
			mul_a = $signed({1'b0, hold_q});
			mul_b = $signed({{(BW - slmph_pkg::SEG_W){1'b0}}, seg});
		end
	end

	assign prod = mul_a * mul_b;

	// smoothing: shown + floor((target - shown) * c / 2^16)
	assign step_v   = prod[slmph_pkg::COEF_W +: AW];
	assign sm_sum   = {1'b0, shown_q} + step_v;
	assign shown_nx = sm_sum[LW-1:0];

	// peak decay, held no lower than the shown level
	assign decayed = prod[slmph_pkg::COEF_W +: LW];
	assign hold_nx = (decayed > shown_q) ? decayed : shown_q;

	// level to segment count, rounded half up
	assign rnd    = $unsigned(prod) + HALF;
	assign n_full = rnd[PW-1:LEVEL_FRAC_BITS];
	assign n_seg  = (n_full > NW'(seg)) ? seg : n_full[slmph_pkg::SEG_W-1:0];

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			shown_q  <= '0;
			hold_q   <= '0;
		end else begin
			if (cmd.load_target) begin
				target_q <= target_nx;
			end
			if (cmd.smooth) begin
				shown_q <= shown_nx;
			end
			if (cmd.decay) begin
				hold_q <= hold_nx;
			end
		end
	end

	// lit count waits for the peak step
	always_ff @(posedge clk) begin
		if (cmd.lit) begin
			lit_q <= n_seg;
		end
	end

	assign lit  = lit_q;
	assign peak = n_seg;

endmodule

// File: design/slmph_dp.sv
module slmph_dp #(
	parameter int LEVEL_FRAC_BITS = slmph_pkg::DEFAULT_LEVEL_FRAC_BITS,
	parameter int MAX_SEGMENTS    = slmph_pkg::DEFAULT_MAX_SEGMENTS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  slmph_pkg::cmd_t                         cmd,
	input  logic                                    cfg_we,
	input  logic [slmph_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [slmph_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [slmph_pkg::LEVEL_IN_W-1:0] level_left,
	input  logic signed [slmph_pkg::LEVEL_IN_W-1:0] level_right,
	output logic [slmph_pkg::SEG_W-1:0]             lit_left,
	output logic [slmph_pkg::SEG_W-1:0]             lit_right,
	output logic [slmph_pkg::SEG_W-1:0]             peak_left,
	output logic [slmph_pkg::SEG_W-1:0]             peak_right
);

	logic [slmph_pkg::COEF_W-1:0] attack_q;
	logic [slmph_pkg::COEF_W-1:0] release_q;
	logic [slmph_pkg::COEF_W-1:0] decay_q;
	logic [slmph_pkg::SEG_W-1:0]  seg_q;
	logic [slmph_pkg::SEG_W-1:0]  seg_eff;

	logic [slmph_pkg::SEG_W-1:0]  lit_l;
	logic [slmph_pkg::SEG_W-1:0]  lit_r;
	logic [slmph_pkg::SEG_W-1:0]  peak_l;
	logic [slmph_pkg::SEG_W-1:0]  peak_r;

	logic [slmph_pkg::SEG_W-1:0]  lit_left_q;
	logic [slmph_pkg::SEG_W-1:0]  lit_right_q;
	logic [slmph_pkg::SEG_W-1:0]  peak_left_q;
	logic [slmph_pkg::SEG_W-1:0]  peak_right_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= slmph_pkg::ATTACK_RESET;
			release_q <= slmph_pkg::RELEASE_RESET;
			decay_q   <= slmph_pkg::DECAY_RESET;
			seg_q     <= slmph_pkg::SEGMENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slmph_pkg::CFG_ATTACK:  attack_q  <= cfg_data;
				slmph_pkg::CFG_RELEASE: release_q <= cfg_data;
				slmph_pkg::CFG_DECAY:   decay_q   <= cfg_data;
				slmph_pkg::CFG_SEGMENT: seg_q     <= cfg_data[slmph_pkg::SEG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// segment count saturates at the column limit
	assign seg_eff = ({1'b0, seg_q} > (slmph_pkg::SEG_W + 1)'(MAX_SEGMENTS))
		? slmph_pkg::SEG_W'(MAX_SEGMENTS) : seg_q;

	slmph_lane #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
	) u_lane_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.level       (level_left),
		.attack_coef (attack_q),
		.release_coef(release_q),
		.peak_decay  (decay_q),
		.seg         (seg_eff),
		.lit         (lit_l),
		.peak        (peak_l)
	);

	slmph_lane #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
	) u_lane_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.level       (level_right),
		.attack_coef (attack_q),
		.release_coef(release_q),
		.peak_decay  (decay_q),
		.seg         (seg_eff),
		.lit         (lit_r),
		.peak        (peak_r)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			lit_left_q   <= lit_l;
			lit_right_q  <= lit_r;
			peak_left_q  <= peak_l;
			peak_right_q <= peak_r;
		end
	end

	assign lit_left   = lit_left_q;
	assign lit_right  = lit_right_q;
	assign peak_left  = peak_left_q;
	assign peak_right = peak_right_q;

endmodule

// File: design/stereo_level_meter_peak_hold_top.sv
// Stereo LED bar level meter with attack/release ballistics and peak hold.
// Input channel (in_valid/in_stall): action 0 beats carry a new left/right
// level pair, clamped to 0..one and stored as targets; they give no result.
// Action 1 beats are display ticks: each gives one result beat with the lit
// segment count and peak-dot position of both columns.
// Output channel (out_valid/out_stall): one result beat per tick.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 attack coef,
// 1 release coef, 2 peak decay, 3 segment count. Write only while idle.
// A level beat is stored when accepted and leaves the controller idle. A tick
// passes the accept step, then one step each of smoothing, peak decay, lit
// rounding and peak rounding on the one multiplier per channel; its result is
// registered as the peak rounding step ends.
// The next beat is accepted as soon as the tick finishes, even while the
// previous result still sits in the output register.
// If the receiver stalls with a result pending, a finished tick waits in
// its last step and in_stall stays high until the output register frees.
// Reset clears targets, shown levels and peak holds to zero and loads the
// default coefficients and segment count; no result is pending.
module stereo_level_meter_peak_hold_top #(
	parameter int LEVEL_FRAC_BITS = slmph_pkg::DEFAULT_LEVEL_FRAC_BITS,
	parameter int MAX_SEGMENTS    = slmph_pkg::DEFAULT_MAX_SEGMENTS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    action,
	input  logic signed [slmph_pkg::LEVEL_IN_W-1:0] level_left,
	input  logic signed [slmph_pkg::LEVEL_IN_W-1:0] level_right,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [slmph_pkg::SEG_W-1:0]             lit_left,
	output logic [slmph_pkg::SEG_W-1:0]             lit_right,
	output logic [slmph_pkg::SEG_W-1:0]             peak_left,
	output logic [slmph_pkg::SEG_W-1:0]             peak_right,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [slmph_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [slmph_pkg::CFG_DATA_W-1:0]        cfg_data
);

	slmph_pkg::cmd_t cmd;

	// register writes are never held off
	assign cfg_ready = 1'b1;

	slmph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	slmph_dp #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
		.MAX_SEGMENTS   (MAX_SEGMENTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.level_left (level_left),
		.level_right(level_right),
		.lit_left   (lit_left),
		.lit_right  (lit_right),
		.peak_left  (peak_left),
		.peak_right (peak_right)
	);

endmodule

// File: bench/slmph_checker.sv
module slmph_checker
	import slmph_pkg::*;
#(
	parameter int LEVEL_FRAC_BITS = DEFAULT_LEVEL_FRAC_BITS,
	parameter int MAX_SEGMENTS    = DEFAULT_MAX_SEGMENTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         action,
	input  logic signed [LEVEL_IN_W-1:0] level_left,
	input  logic signed [LEVEL_IN_W-1:0] level_right,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [SEG_W-1:0]             lit_left,
	input  logic [SEG_W-1:0]             lit_right,
	input  logic [SEG_W-1:0]             peak_left,
	input  logic [SEG_W-1:0]             peak_right,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output int                           mismatches,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned FULL_SCALE = 64'd1 << LEVEL_FRAC_BITS;

	// one display beat: bar heights and peak dots of both columns
	typedef struct packed {
		logic [SEG_W-1:0] lit_l;
		logic [SEG_W-1:0] lit_r;
		logic [SEG_W-1:0] peak_l;
		logic [SEG_W-1:0] peak_r;
	} bars_t;

	// register copies
	longint unsigned attack_w, release_w, decay_w, seg_cfg;
	// meter state
	longint unsigned target_l, target_r, shown_l, shown_r, hold_l, hold_r;

	bars_t expected_bars[$];
	bars_t got;

	initial mismatches = 0;

	// negative levels go to zero, anything above full scale saturates
	function automatic longint unsigned clamp_level(logic [LEVEL_IN_W-1:0] raw);
		if (raw[LEVEL_IN_W-1])
			return 0;
		if (raw > FULL_SCALE)
			return FULL_SCALE;
		return raw;
	endfunction

	// one-pole ballistics, attack when rising, release otherwise
	function automatic longint unsigned follow_level(longint unsigned tgt, longint unsigned cur);
		longint unsigned c;
		c = (tgt > cur) ? attack_w : release_w;
		return (cur * (64'd65536 - c) + tgt * c) >> 16;
	endfunction

	// peak decays geometrically but never drops below the bar
	function automatic longint unsigned decay_peak(longint unsigned hold, longint unsigned shown);
		longint unsigned d;
		d = (hold * decay_w) >> 16;
		return (d > shown) ? d : shown;
	endfunction

	// level to segment count, round half up
	function automatic logic [SEG_W-1:0] to_bar(longint unsigned x, longint unsigned seg);
		longint unsigned n;
		n = (x * seg + (FULL_SCALE >> 1)) >> LEVEL_FRAC_BITS;
		if (n > seg)
			n = seg;
		return n[SEG_W-1:0];
	endfunction

	function automatic bars_t meter_tick();
		bars_t b;
		longint unsigned seg;
		shown_l = follow_level(target_l, shown_l);
		shown_r = follow_level(target_r, shown_r);
		hold_l  = decay_peak(hold_l, shown_l);
		hold_r  = decay_peak(hold_r, shown_r);
		seg = (seg_cfg > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_cfg;
		b.lit_l  = to_bar(shown_l, seg);
		b.lit_r  = to_bar(shown_r, seg);
		b.peak_l = to_bar(hold_l, seg);
		b.peak_r = to_bar(hold_r, seg);
		return b;
	endfunction

	task automatic check_field(string name, logic [SEG_W-1:0] want, logic [SEG_W-1:0] seen);
		if (seen !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
		end
	endtask

	// watch all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_w  = ATTACK_RESET;
			release_w = RELEASE_RESET;
			decay_w   = DECAY_RESET;
			seg_cfg   = SEGMENT_RESET;
			target_l  = 0;
			target_r  = 0;
			shown_l   = 0;
			shown_r   = 0;
			hold_l    = 0;
			hold_r    = 0;
			expected_bars.delete();
			outstanding = 0;
		end else begin
			// result beat against oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_bars.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none, got %0d %0d %0d %0d",
						$time, lit_left, lit_right, peak_left, peak_right);
				end else begin
					got = expected_bars.pop_front();
					check_field("lit_left", got.lit_l, lit_left);
					check_field("lit_right", got.lit_r, lit_right);
					check_field("peak_left", got.peak_l, peak_left);
					check_field("peak_right", got.peak_r, peak_right);
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ATTACK:  attack_w  = cfg_data;
					CFG_RELEASE: release_w = cfg_data;
					CFG_DECAY:   decay_w   = cfg_data;
					CFG_SEGMENT: seg_cfg   = cfg_data[SEG_W-1:0];
					default: ;
				endcase
			end
			// input beat
			if (in_valid && !in_stall) begin
				if (action == ACT_LEVEL) begin
					target_l = clamp_level(level_left);
					target_r = clamp_level(level_right);
				end else begin
					expected_bars.push_back(meter_tick());
				end
			end
			outstanding = expected_bars.size();
		end
	end

endmodule

// File: bench/tb_stereo_level_meter_peak_hold_top.sv
module tb_stereo_level_meter_peak_hold_top;
	import slmph_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 108;
	localparam int SETTLE_CYCLES = 8;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         action;
	logic signed [LEVEL_IN_W-1:0] level_left;
	logic signed [LEVEL_IN_W-1:0] level_right;
	logic                         out_valid;
	logic                         out_stall;
	logic [SEG_W-1:0]             lit_left;
	logic [SEG_W-1:0]             lit_right;
	logic [SEG_W-1:0]             peak_left;
	logic [SEG_W-1:0]             peak_right;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;

	int mismatches;
	int outstanding;
	int gap_pct;
	int stall_pct;
	int tick_pct;
	int cycle_count;

	stereo_level_meter_peak_hold_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.level_left (level_left),
		.level_right(level_right),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lit_left   (lit_left),
		.lit_right  (lit_right),
		.peak_left  (peak_left),
		.peak_right (peak_right),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	slmph_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.level_left (level_left),
		.level_right(level_right),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lit_left   (lit_left),
		.lit_right  (lit_right),
		.peak_left  (peak_left),
		.peak_right (peak_right),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// one input beat, called and returning at a falling edge
	task automatic send_beat(logic act, logic signed [LEVEL_IN_W-1:0] l,
			logic signed [LEVEL_IN_W-1:0] r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		level_left  <= l;
		level_right <= r;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// write all four registers back to back
	task automatic set_meter(logic [CFG_DATA_W-1:0] att, logic [CFG_DATA_W-1:0] rel,
			logic [CFG_DATA_W-1:0] dec, logic [CFG_DATA_W-1:0] seg);
		write_reg(CFG_ATTACK, att);
		write_reg(CFG_RELEASE, rel);
		write_reg(CFG_DECAY, dec);
		write_reg(CFG_SEGMENT, seg);
		cfg_valid <= 1'b0;
	endtask

	// hold off the sender until every pending display beat is out
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [LEVEL_IN_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return LEVEL_IN_W'($urandom_range(0, 32768));
			6:       return 17'sd32768;
			7:       return '0;
			default: return LEVEL_IN_W'($urandom_range(0, 131071));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_segments();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'd32;
			3:       return CFG_DATA_W'($urandom_range(33, 63));
			4:       return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'($urandom_range(1, 32));
		endcase
	endfunction

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_LEVEL;
		level_left  = '0;
		level_right = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_ATTACK;
		cfg_data    = '0;
		gap_pct     = 0;
		stall_pct   = 0;
		tick_pct    = 50;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, full scale, clamping both ways
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_LEVEL, 17'sd32768, '0);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_LEVEL, 17'sd65535, -17'sd65536);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_LEVEL, 17'sd32769, -17'sd1);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_LEVEL, '0, 17'sd32767);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_TICK, '0, '0);

		// zero coefficients freeze levels and drop peaks, zero segments blank
		settle();
		set_meter('0, '0, '0, '0);
		send_beat(ACT_LEVEL, 17'sd32768, 17'sd32768);
		send_beat(ACT_TICK, '0, '0);

		// largest coefficients, segment count above the limit saturates
		settle();
		set_meter('1, '1, '1, 16'd63);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_LEVEL, '0, '0);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_TICK, '0, '0);

		// single segment
		settle();
		set_meter(ATTACK_RESET, RELEASE_RESET, DECAY_RESET, 16'd1);
		send_beat(ACT_TICK, '0, '0);

		// zero decay coefficient, full column
		settle();
		set_meter(ATTACK_RESET, RELEASE_RESET, '0, 16'd32);
		send_beat(ACT_LEVEL, 17'sd16384, 17'sd12345);
		send_beat(ACT_TICK, '0, '0);
		send_beat(ACT_TICK, '0, '0);

		// random phases, each with fresh settings and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_meter(pick_coef(), pick_coef(), pick_coef(), pick_segments());
			case (p % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 76;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 76;
				end
				default: begin
					gap_pct   = 37;
					stall_pct = 37;
				end
			endcase
			tick_pct = $urandom_range(25, 75);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < tick_pct)
					send_beat(ACT_TICK, LEVEL_IN_W'($urandom()), LEVEL_IN_W'($urandom()));
				else
					send_beat(ACT_LEVEL, pick_level(), pick_level());
			end
		end

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
